FILE: rtl/klx_pkg.sv
// ---------------------------------------------------------------------------
// klx_pkg: shared types and constants of the keyword token lexer
// Token kinds, scan modes, keyword prefix codes, character classes and the
// result record that travels from the scanner to the output queue.
// ---------------------------------------------------------------------------
package klx_pkg;

	localparam int LenBitsDef = 16;
	localparam int QDepth     = 4;
	localparam int OutLenW    = 16;

	typedef enum logic [3:0] {
		KIND_EOF    = 4'd0,
		KIND_FN     = 4'd1,
		KIND_END    = 4'd2,
		KIND_IF     = 4'd3,
		KIND_DO     = 4'd4,
		KIND_IDENT  = 4'd5,
		KIND_NUMBER = 4'd6,
		KIND_STRING = 4'd7,
		KIND_CHAR   = 4'd8,
		KIND_ERROR  = 4'd9
	} tok_kind_t;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_IDENT   = 5'b00010,
		MODE_NUMBER  = 5'b00100,
		MODE_STRING  = 5'b01000,
		MODE_COMMENT = 5'b10000
	} mode_t;

	// Keyword prefix tracker codes.
	localparam logic [3:0] KW_DEAD = 4'd0;
	localparam logic [3:0] KW_F    = 4'd1;
	localparam logic [3:0] KW_FN   = 4'd2;
	localparam logic [3:0] KW_E    = 4'd3;
	localparam logic [3:0] KW_EN   = 4'd4;
	localparam logic [3:0] KW_END  = 4'd5;
	localparam logic [3:0] KW_I    = 4'd6;
	localparam logic [3:0] KW_IF   = 4'd7;
	localparam logic [3:0] KW_D    = 4'd8;
	localparam logic [3:0] KW_DO   = 4'd9;

	// Character codes.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LD    = 8'h64;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_LF_F  = 8'h66;
	localparam logic [7:0] CH_LI    = 8'h69;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LO    = 8'h6F;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	typedef struct packed {
		tok_kind_t          kind;
		logic [7:0]         code;
		logic [OutLenW-1:0] len;
		logic               last;
	} res_t;

	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_quote(logic [7:0] c);
		return c == CH_DQUOT || c == CH_SQUOT;
	endfunction

	function automatic logic [3:0] kw_start(logic [7:0] c);
		logic [3:0] s;
		case (c)
			CH_LF_F: s = KW_F;
			CH_LE:   s = KW_E;
			CH_LI:   s = KW_I;
			CH_LD:   s = KW_D;
			default: s = KW_DEAD;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] kw_next(logic [3:0] s, logic [7:0] c);
		logic [3:0] n;
		n = KW_DEAD;
		if (s == KW_F && c == CH_LN) n = KW_FN;
		if (s == KW_E && c == CH_LN) n = KW_EN;
		if (s == KW_EN && c == CH_LD) n = KW_END;
		if (s == KW_I && c == CH_LF_F) n = KW_IF;
		if (s == KW_D && c == CH_LO) n = KW_DO;
		return n;
	endfunction

	function automatic tok_kind_t kw_kind(logic [3:0] s);
		tok_kind_t k;
		case (s)
			KW_FN:   k = KIND_FN;
			KW_END:  k = KIND_END;
			KW_IF:   k = KIND_IF;
			KW_DO:   k = KIND_DO;
			default: k = KIND_IDENT;
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/klx_scan.sv
// ---------------------------------------------------------------------------
// klx_scan: token scanner
// Holds the scan mode, token length and keyword prefix, and turns one
// accepted character into up to two token results in the same cycle.
// ---------------------------------------------------------------------------
module klx_scan #(
	parameter int LEN_BITS = klx_pkg::LenBitsDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  logic [7:0]      char_in,
	input  logic            end_of_stream,
	output klx_pkg::push_t  push
);

	localparam int ExtW = (LEN_BITS > klx_pkg::OutLenW) ? LEN_BITS : klx_pkg::OutLenW;

	klx_pkg::mode_t      mode_q, mode_d;
	logic [LEN_BITS-1:0] len_q, len_d;
	logic [3:0]          kw_q, kw_d;

	logic                v0, v1;
	klx_pkg::res_t       r0, r1;

	function automatic logic [klx_pkg::OutLenW-1:0] sat_len(logic [LEN_BITS-1:0] v);
		logic [ExtW-1:0] e;
		e = ExtW'(v);
		if (e > ExtW'({klx_pkg::OutLenW{1'b1}})) begin
			return {klx_pkg::OutLenW{1'b1}};
		end
		return e[klx_pkg::OutLenW-1:0];
	endfunction

	function automatic logic [LEN_BITS-1:0] bump(logic [LEN_BITS-1:0] v);
		if (v == {LEN_BITS{1'b1}}) begin
			return v;
		end
		return v + LEN_BITS'(1);
	endfunction

	always_comb begin
		klx_pkg::res_t single;
		klx_pkg::res_t tok;
		logic          restart;

		mode_d  = mode_q;
		len_d   = len_q;
		kw_d    = kw_q;
		v0      = 1'b0;
		v1      = 1'b0;
		r0      = '0;
		r1      = '0;
		restart = 1'b0;
		tok     = '0;
		single  = '{kind: klx_pkg::KIND_CHAR, code: char_in,
			len: klx_pkg::OutLenW'(1), last: 1'b0};

		if (end_of_stream) begin
			case (mode_q)
				klx_pkg::MODE_IDENT: begin
					v0 = 1'b1;
					r0.kind = klx_pkg::kw_kind(kw_q);
					r0.len = sat_len(len_q);
				end
				klx_pkg::MODE_NUMBER: begin
					v0 = 1'b1;
					r0.kind = klx_pkg::KIND_NUMBER;
					r0.len = sat_len(len_q);
				end
				klx_pkg::MODE_STRING: begin
					v0 = 1'b1;
					r0.kind = klx_pkg::KIND_ERROR;
					r0.len = sat_len(len_q);
				end
				default: begin
				end
			endcase
			// The end-of-file token follows whatever token was still open.
			if (v0) begin
				v1 = 1'b1;
			end else begin
				v0 = 1'b1;
			end
			mode_d = klx_pkg::MODE_IDLE;
			len_d  = '0;
			kw_d   = klx_pkg::KW_DEAD;
		end else begin
			case (mode_q)
				klx_pkg::MODE_IDENT: begin
					if (klx_pkg::is_alpha(char_in) || klx_pkg::is_digit(char_in)) begin
						len_d = bump(len_q);
						kw_d  = klx_pkg::kw_next(kw_q, char_in);
					end else begin
						v0 = 1'b1;
						r0.kind = klx_pkg::kw_kind(kw_q);
						r0.len = sat_len(len_q);
						restart = 1'b1;
					end
				end
				klx_pkg::MODE_NUMBER: begin
					if (klx_pkg::is_digit(char_in) || char_in == klx_pkg::CH_DOT) begin
						len_d = bump(len_q);
					end else begin
						v0 = 1'b1;
						r0.kind = klx_pkg::KIND_NUMBER;
						r0.len = sat_len(len_q);
						restart = 1'b1;
					end
				end
				klx_pkg::MODE_STRING: begin
					if (klx_pkg::is_quote(char_in)) begin
						v0 = 1'b1;
						r0.kind = klx_pkg::KIND_STRING;
						r0.len = sat_len(len_q);
						mode_d = klx_pkg::MODE_IDLE;
						len_d  = '0;
						kw_d   = klx_pkg::KW_DEAD;
					end else begin
						len_d = bump(len_q);
					end
				end
				klx_pkg::MODE_COMMENT: begin
					if (char_in == klx_pkg::CH_LF || char_in == klx_pkg::CH_CR) begin
						mode_d = klx_pkg::MODE_IDLE;
						len_d  = '0;
						kw_d   = klx_pkg::KW_DEAD;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase

			// The character that ended a token is scanned again as a fresh start.
			if (restart) begin
				mode_d = klx_pkg::MODE_IDLE;
				len_d  = '0;
				kw_d   = klx_pkg::KW_DEAD;
				if (klx_pkg::is_alpha(char_in)) begin
					mode_d = klx_pkg::MODE_IDENT;
					len_d  = LEN_BITS'(1);
					kw_d   = klx_pkg::kw_start(char_in);
				end else if (klx_pkg::is_digit(char_in)) begin
					mode_d = klx_pkg::MODE_NUMBER;
					len_d  = LEN_BITS'(1);
				end else if (klx_pkg::is_quote(char_in)) begin
					mode_d = klx_pkg::MODE_STRING;
				end else if (char_in == klx_pkg::CH_HASH) begin
					mode_d = klx_pkg::MODE_COMMENT;
				end else if (!klx_pkg::is_space(char_in)) begin
					if (v0) begin
						v1 = 1'b1;
						r1 = single;
					end else begin
						v0 = 1'b1;
						r0 = single;
					end
				end
			end
		end

		if (v1) begin
			r1.last = 1'b1;
		end else if (v0) begin
			r0.last = 1'b1;
		end

		tok  = r0;
		push = '{v0: acc & v0, v1: acc & v1, r0: tok, r1: r1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= klx_pkg::MODE_IDLE;
			len_q  <= '0;
			kw_q   <= klx_pkg::KW_DEAD;
		end else if (acc) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			kw_q   <= kw_d;
		end
	end

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second result without a first one");

	a_eos_ends_in_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && end_of_stream) |->
		((push.v1 && push.r1.kind == klx_pkg::KIND_EOF && push.r1.last) ||
		 (!push.v1 && push.v0 && push.r0.kind == klx_pkg::KIND_EOF && push.r0.last)))
		else $error("end of stream did not close with an eof token");

	a_eos_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && end_of_stream) |=> (mode_q == klx_pkg::MODE_IDLE && len_q == '0))
		else $error("scanner not idle after end of stream");

endmodule

FILE: rtl/klx_outq.sv
// ---------------------------------------------------------------------------
// klx_outq: token result queue
// Small queue that takes up to two results per cycle and hands one result
// per transfer to the output channel.
// ---------------------------------------------------------------------------
module klx_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  klx_pkg::push_t push,
	output logic           room,
	output logic           head_valid,
	input  logic           head_stall,
	output klx_pkg::res_t  head
);

	localparam int PtrW = $clog2(klx_pkg::QDepth);
	localparam int CntW = $clog2(klx_pkg::QDepth + 1);

	klx_pkg::res_t  slot_q [klx_pkg::QDepth];
	logic [PtrW-1:0] rd_q, wr_q;
	logic [CntW-1:0] cnt_q;
	logic            pop;
	logic [PtrW-1:0] wr_next;

	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rd_q];
	assign pop        = head_valid & ~head_stall;
	// An item may enter only when both of its possible results fit.
	assign room       = cnt_q <= CntW'(klx_pkg::QDepth - 2);
	assign wr_next    = wr_q + PtrW'(1);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			slot_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			slot_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PtrW'(push.v0) + PtrW'(push.v1);
			rd_q  <= rd_q + PtrW'(pop);
			cnt_q <= cnt_q + CntW'(push.v0) + CntW'(push.v1) - CntW'(pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(klx_pkg::QDepth))
		else $error("result queue overfilled");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> room)
		else $error("results pushed without room");

endmodule

FILE: rtl/keyword_token_lexer_top.sv
// ---------------------------------------------------------------------------
// keyword_token_lexer_top: keyword token lexer
// Scans a character stream one byte per transfer and emits a token record
// whenever a token ends, recognizing the keywords fn, end, if and do.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   src      | src_valid / src_stall  | char_in, end_of_stream
//   tok      | tok_valid / tok_stall  | token_kind, char_code,
//            |                        | token_length, last
//
// A character is scanned in the cycle it is accepted; its results sit in a
// four-entry queue and are offered from the next cycle on.
// One character per cycle is taken while each character yields at most one
// token and tok_stall stays low; a character that yields two tokens needs two token transfers.
// src_stall rises when the queue cannot hold two more results, so it
// follows tok_stall with a few entries of slack.
// Reset empties the queue and returns the scanner to idle between tokens.
// ---------------------------------------------------------------------------
module keyword_token_lexer_top #(
	parameter int LEN_BITS = klx_pkg::LenBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_stream,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [3:0]  token_kind,
	output logic [7:0]  char_code,
	output logic [15:0] token_length,
	output logic        last
);

	klx_pkg::push_t push;
	klx_pkg::res_t  head;
	logic           room;
	logic           acc;

	assign src_stall = ~room;
	assign acc       = src_valid & room;

	klx_scan #(
		.LEN_BITS(LEN_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.char_in      (char_in),
		.end_of_stream(end_of_stream),
		.push         (push)
	);

	klx_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.head_valid(tok_valid),
		.head_stall(tok_stall),
		.head      (head)
	);

	assign token_kind   = head.kind;
	assign char_code    = head.code;
	assign token_length = head.len;
	assign last         = head.last;

endmodule

FILE: sim/keyword_token_lexer_checker.sv
// ---------------------------------------------------------------------------
// keyword_token_lexer_checker: token predictor and scoreboard
// Watches both channels of the keyword token lexer. Every character transfer
// runs through a local copy of the scanner, which queues the tokens it should
// produce. Every token transfer is compared field by field with the oldest of
// them. The failure count and the number of tokens still due go to the top.
// ---------------------------------------------------------------------------
module keyword_token_lexer_checker
	import klx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	input  logic        src_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_stream,
	input  logic        tok_valid,
	input  logic        tok_stall,
	input  logic [3:0]  token_kind,
	input  logic [7:0]  char_code,
	input  logic [15:0] token_length,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          tokens_checked
);

	localparam int CountW = LenBitsDef;

	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  code;
		logic [15:0] len;
		logic        fin;
	} token_t;

	token_t expected_tokens[$];
	token_t fresh[$];

	mode_t             scan = MODE_IDLE;
	logic [CountW-1:0] body_count = '0;
	logic [3:0]        kw_prefix = KW_DEAD;
	logic              body_saturated = 1'b0;
	int                fails = 0;
	int                checked = 0;

	function automatic logic letter(logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic digit(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic quote(logic [7:0] c);
		return c == CH_DQUOT || c == CH_SQUOT;
	endfunction

	function automatic logic [3:0] prefix_after_first(logic [7:0] c);
		case (c)
			CH_LF_F: return KW_F;
			CH_LE:   return KW_E;
			CH_LI:   return KW_I;
			CH_LD:   return KW_D;
			default: return KW_DEAD;
		endcase
	endfunction

	function automatic logic [3:0] prefix_advance(logic [3:0] p, logic [7:0] c);
		case (p)
			KW_F:    return (c == CH_LN) ? KW_FN : KW_DEAD;
			KW_E:    return (c == CH_LN) ? KW_EN : KW_DEAD;
			KW_EN:   return (c == CH_LD) ? KW_END : KW_DEAD;
			KW_I:    return (c == CH_LF_F) ? KW_IF : KW_DEAD;
			KW_D:    return (c == CH_LO) ? KW_DO : KW_DEAD;
			default: return KW_DEAD;
		endcase
	endfunction

	function automatic tok_kind_t kind_of_prefix(logic [3:0] p);
		case (p)
			KW_FN:   return KIND_FN;
			KW_END:  return KIND_END;
			KW_IF:   return KIND_IF;
			KW_DO:   return KIND_DO;
			default: return KIND_IDENT;
		endcase
	endfunction

	// The internal count may be wider than the reported field.
	function automatic logic [15:0] shown_length();
		return (body_count > 'hFFFF) ? 16'hFFFF : 16'(body_count);
	endfunction

	function automatic void add_token(tok_kind_t k, logic [7:0] c, logic [15:0] n);
		token_t t;
		t.kind = k;
		t.code = c;
		t.len = n;
		t.fin = 1'b0;
		fresh.push_back(t);
	endfunction

	function automatic void grow();
		if (body_count != '1)
			body_count++;
		else
			body_saturated = 1'b1;
	endfunction

	function automatic void drop_token();
		scan = MODE_IDLE;
		body_count = '0;
		kw_prefix = KW_DEAD;
		body_saturated = 1'b0;
	endfunction

	// A character seen between tokens: it starts a token, is skipped, or is
	// a token of its own.
	function automatic void open_token(logic [7:0] c);
		drop_token();
		if (blank(c)) begin
		end else if (letter(c)) begin
			scan = MODE_IDENT;
			body_count = CountW'(1);
			kw_prefix = prefix_after_first(c);
		end else if (digit(c)) begin
			scan = MODE_NUMBER;
			body_count = CountW'(1);
		end else if (quote(c)) begin
			scan = MODE_STRING;
		end else if (c == CH_HASH) begin
			scan = MODE_COMMENT;
		end else begin
			add_token(KIND_CHAR, c, 16'd1);
		end
	endfunction

	task automatic consume_char(input logic [7:0] c, input logic eos);
		token_t t;
		fresh.delete();
		if (eos) begin
			case (scan)
				MODE_IDENT:  add_token(kind_of_prefix(kw_prefix), 8'h00, shown_length());
				MODE_NUMBER: add_token(KIND_NUMBER, 8'h00, shown_length());
				MODE_STRING: add_token(KIND_ERROR, 8'h00, shown_length());
				default: ;
			endcase
			add_token(KIND_EOF, 8'h00, 16'd0);
			drop_token();
		end else begin
			case (scan)
				MODE_IDENT: begin
					if (letter(c) || digit(c)) begin
						grow();
						kw_prefix = prefix_advance(kw_prefix, c);
					end else begin
						add_token(kind_of_prefix(kw_prefix), 8'h00, shown_length());
						open_token(c);
					end
				end
				MODE_NUMBER: begin
					if (digit(c) || c == CH_DOT) begin
						grow();
					end else begin
						add_token(KIND_NUMBER, 8'h00, shown_length());
						open_token(c);
					end
				end
				MODE_STRING: begin
					if (quote(c)) begin
						add_token(KIND_STRING, 8'h00, shown_length());
						drop_token();
					end else begin
						grow();
					end
				end
				MODE_COMMENT: begin
					if (c == CH_LF || c == CH_CR)
						drop_token();
				end
				default: open_token(c);
			endcase
		end
		if (fresh.size() != 0) begin
			t = fresh.pop_back();
			t.fin = 1'b1;
			fresh.push_back(t);
		end
		foreach (fresh[i])
			expected_tokens.push_back(fresh[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			drop_token();
			expected_tokens.delete();
			fails = 0;
			checked = 0;
			fail_count <= 0;
			pending <= 0;
			tokens_checked <= 0;
		end else begin
			// Prediction first, so a token is never compared against a
			// queue that is missing the entry of this same edge.
			if (src_valid && !src_stall)
				consume_char(char_in, end_of_stream);
			if (tok_valid && !tok_stall) begin
				if (expected_tokens.size() == 0) begin
					$error("token transfer with nothing expected: kind %0d, code %0d, length %0d",
						token_kind, char_code, token_length);
					fails++;
				end else begin
					want = expected_tokens.pop_front();
					checked++;
					if (token_kind !== want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
						fails++;
					end
					if (char_code !== want.code) begin
						$error("char_code: expected %0d, got %0d", want.code, char_code);
						fails++;
					end
					if (token_length !== want.len) begin
						$error("token_length: expected %0d, got %0d", want.len, token_length);
						fails++;
					end
					if (last !== want.fin) begin
						$error("last: expected %0d, got %0d", want.fin, last);
						fails++;
					end
				end
			end
			fail_count <= fails;
			pending <= expected_tokens.size();
			tokens_checked <= checked;
		end
	end

endmodule

FILE: sim/keyword_token_lexer_top_test.sv
// ---------------------------------------------------------------------------
// keyword_token_lexer_top_test: testbench of the keyword token lexer
// Feeds a directed character stream covering keywords, every token class,
// tab, CR, VT and FF whitespace bytes, high bytes and every way a stream
// can end, then a random stream built mostly of well-formed tokens. The
// sender works in bursts and the receiver stalls on its own pattern; a
// checker beside the block predicts and compares every token.
// ---------------------------------------------------------------------------
module keyword_token_lexer_top_test;
	import klx_pkg::*;

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        src_valid;
	logic        src_stall;
	logic [7:0]  char_in;
	logic        end_of_stream;
	logic        tok_valid;
	logic        tok_stall;
	logic [3:0]  token_kind;
	logic [7:0]  char_code;
	logic [15:0] token_length;
	logic        last;

	int fail_count;
	int pending;
	int tokens_checked;

	int   burst_left = 0;
	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	logic paused = 1'b0;
	int   items_sent = 0;
	int   eos_sent = 0;
	int   stall_left = 0;
	logic hold;

	string punct = "!$%&()*+,-./:;<=>?@[]^_`{|}~\\";

	keyword_token_lexer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.char_in      (char_in),
		.end_of_stream(end_of_stream),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.char_code    (char_code),
		.token_length (token_length),
		.last         (last)
	);

	keyword_token_lexer_checker watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.src_valid     (src_valid),
		.src_stall     (src_stall),
		.char_in       (char_in),
		.end_of_stream (end_of_stream),
		.tok_valid     (tok_valid),
		.tok_stall     (tok_stall),
		.token_kind    (token_kind),
		.char_code     (char_code),
		.token_length  (token_length),
		.last          (last),
		.fail_count    (fail_count),
		.pending       (pending),
		.tokens_checked(tokens_checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One character transfer. Gaps fall between bursts; valid is only
	// lowered when a gap follows, so it never toggles within one step.
	task automatic send(input logic [7:0] c, input logic e);
		int gap;
		if (burst_left == 0) begin
			gap = tx_quiet ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = tx_quiet ? 1000 : $urandom_range(1, 24);
		end
		src_valid <= 1'b1;
		char_in <= c;
		end_of_stream <= e;
		do @(posedge clk); while (src_stall);
		burst_left--;
		items_sent++;
		if (e)
			eos_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i], 1'b0);
	endtask

	task automatic send_eos();
		send(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [7:0] letter_byte();
		return 8'($urandom_range(0, 1) ? CH_LA + $urandom_range(0, 25)
			: CH_UA + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] alnum_byte();
		return ($urandom_range(0, 3) == 0) ? 8'(CH_0 + $urandom_range(0, 9)) : letter_byte();
	endfunction

	function automatic logic [7:0] string_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_DQUOT || b == CH_SQUOT);
		return b;
	endfunction

	function automatic logic [7:0] blank_byte();
		return ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
	endfunction

	task automatic send_random_token();
		int pick;
		int n;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			case ($urandom_range(0, 3))
				0: send_text("fn");
				1: send_text("end");
				2: send_text("if");
				default: send_text("do");
			endcase
			if ($urandom_range(0, 3) == 0)
				send(alnum_byte(), 1'b0);
		end else if (pick < 18) begin
			// Broken keywords: prefixes, wrong case and overruns.
			case ($urandom_range(0, 7))
				0: send_text("f");
				1: send_text("e");
				2: send_text("en");
				3: send_text("i");
				4: send_text("d");
				5: send_text("endd");
				6: send_text("iF");
				default: send_text("Do");
			endcase
		end else if (pick < 30) begin
			send(letter_byte(), 1'b0);
			n = $urandom_range(0, 7);
			repeat (n) send(alnum_byte(), 1'b0);
		end else if (pick < 42) begin
			send(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
			n = $urandom_range(0, 6);
			repeat (n) send(($urandom_range(0, 3) == 0) ? CH_DOT
				: 8'(CH_0 + $urandom_range(0, 9)), 1'b0);
		end else if (pick < 56) begin
			send($urandom_range(0, 1) ? CH_DQUOT : CH_SQUOT, 1'b0);
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (n) send(string_byte(), 1'b0);
			send($urandom_range(0, 1) ? CH_DQUOT : CH_SQUOT, 1'b0);
		end else if (pick < 64) begin
			send(CH_HASH, 1'b0);
			n = $urandom_range(0, 6);
			repeat (n) begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
				send(b, 1'b0);
			end
			send($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
		end else if (pick < 74) begin
			case ($urandom_range(0, 2))
				0: b = punct[$urandom_range(0, punct.len() - 1)];
				1: b = 8'($urandom_range(128, 255));
				default: b = 8'($urandom_range(0, 1) ? $urandom_range(0, 8)
					: $urandom_range(14, 31));
			endcase
			send(b, 1'b0);
		end else if (pick < 86) begin
			n = $urandom_range(1, 3);
			repeat (n) send(blank_byte(), 1'b0);
		end else if (pick < 95) begin
			n = $urandom_range(1, 3);
			repeat (n) send(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_eos();
		end
	endtask

	// Receiver: runs of stalls and of free flow, with quiet stretches.
	initial begin
		tok_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
			end else begin
				if ($urandom_range(0, 29) == 0)
					rx_quiet = !rx_quiet;
				hold = !rx_quiet && ($urandom_range(0, 2) == 0);
				stall_left = hold ? $urandom_range(0, 7) : $urandom_range(0, 11);
				tok_stall <= hold;
			end
		end
	end

	initial begin
		src_valid <= 1'b0;
		char_in <= 8'h00;
		end_of_stream <= 1'b0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// Every keyword, the empty string, a comment, and a stream that
		// ends inside a string.
		send_text("fn\tend;if\"\"\rdo#c\n9.5'ab");
		send(8'hA5, 1'b1);
		// Two more whitespace bytes, extreme bytes, and the other endings.
		send(CH_VT, 1'b0);
		send(CH_FF, 1'b0);
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send_text("Q7");
		send(8'h00, 1'b1);
		send_text("4");
		send_eos();
		send_text("#");
		send_eos();
		send_eos();

		while (items_sent < 590) begin
			if ($urandom_range(0, 39) == 0)
				tx_quiet = !tx_quiet;
			send_random_token();
			if (!paused && items_sent >= 300) begin
				drain();
				paused = 1'b1;
			end
		end
		send_eos();

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d characters with %0d end-of-stream marks in bursts,",
			items_sent, eos_sent);
		$display("against a stalling receiver; %0d tokens compared.", tokens_checked);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#500_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
